FILE: hdl/hash_db_record_header_parser_core_assert.svh
`ifndef HASH_DB_RECORD_HEADER_PARSER_CORE_ASSERT_SVH
`define HASH_DB_RECORD_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HDBHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hdbhp assertion failed");

// next-cycle implication, checked out of reset
`define HDBHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hdbhp assertion failed");

`endif

FILE: hdl/hdbhp_pkg.sv
package hdbhp_pkg;

  localparam int unsigned OffsetBits = 48;
  localparam int unsigned LenBits    = 34;

  localparam logic [7:0] MagicData = 8'hc8;
  localparam logic [7:0] MagicFree = 8'hb0;

  localparam logic [1:0] RegWidePtr  = 2'd0;
  localparam logic [1:0] RegAlign    = 2'd1;
  localparam logic [1:0] RegStartPos = 2'd2;

  localparam logic [4:0] AlignReset = 5'd4;

  typedef enum logic [8:0] {
    PH_HUNT  = 9'b000000001,
    PH_HASH  = 9'b000000010,
    PH_LEFT  = 9'b000000100,
    PH_RIGHT = 9'b000001000,
    PH_PAD   = 9'b000010000,
    PH_KEY   = 9'b000100000,
    PH_VAL   = 9'b001000000,
    PH_FREE  = 9'b010000000,
    PH_SKIP  = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic                  record_kind;
    logic                  offset_overflow;
    logic [31:0]           value_size;
    logic [31:0]           key_len;
    logic [15:0]           pad_len;
    logic [OffsetBits-1:0] right_offset;
    logic [OffsetBits-1:0] left_offset;
    logic [7:0]            hash_byte;
    logic [LenBits-1:0]    record_length;
    logic [OffsetBits-1:0] rec_offset;
  } result_t;

endpackage

FILE: hdl/hash_db_record_header_parser_core.sv
// a header's result is registered into the output buffer on its last byte transfer
// throughput: one byte per cycle when not stalled; single-pass parse, byte-wide input
// a two-entry output buffer holds results, the input stalls only while both are full
// the input also stalls in the access cycle of a register write
// reset (asynchronous, active low): registers to defaults, parser hunting, position zero
`include "hash_db_record_header_parser_core_assert.svh"

module hash_db_record_header_parser_core import hdbhp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // data_byte
  input  logic [7:0]   s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rec_offset, record_length, hash_byte, left_offset, right_offset,
  // pad_len, key_len, value_size, offset_overflow, zero fill
  output logic [271:0] m_axis_tdata,
  // record_kind
  output logic         m_axis_tuser
);

  logic                  wide_q, wide_d;
  logic [4:0]            shift_q, shift_d;
  logic [OffsetBits-1:0] start_q, start_d;
  phase_e                state_q, state_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] rec_start_q, rec_start_d;
  logic [3:0]            idx_q, idx_d;
  logic [63:0]           acc_q, acc_d;
  logic [2:0]            vcnt_q, vcnt_d;
  logic [7:0]            hcnt_q, hcnt_d;
  logic [LenBits-1:0]    skip_q, skip_d;
  logic [7:0]            hash_q, hash_d;
  logic [OffsetBits-1:0] left_q, left_d;
  logic [OffsetBits-1:0] right_q, right_d;
  logic [15:0]           pad_q, pad_d;
  logic [31:0]           key_q, key_d;
  logic                  ovf_q, ovf_d;

  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    res_valid;

  logic        cfg_wr, s_fire, pop;
  logic [7:0]  b;
  logic [63:0] acc_ins;
  logic [3:0]  idx_inc;
  logic [3:0]  fld_width;
  logic        fld_done;
  logic [127:0] shift_wide;
  logic        ptr_ovf;
  logic [6:0]  digit;
  logic [35:0] vadd, vacc;
  logic [31:0] vsat;
  logic [2:0]  vcnt_inc;
  logic [7:0]  hcnt_inc;
  logic [LenBits-1:0] body;
  logic [LenBits:0]   data_len;
  logic [LenBits-1:0] data_len_sat;
  logic [LenBits-1:0] free_len;
  logic [LenBits-1:0] skip_dec;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign s_axis_tready = !skid_valid_q & !cfg_wr;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign pop           = out_valid_q & m_axis_tready;
  assign b             = s_axis_tdata;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.record_kind;
  assign m_axis_tdata  = {5'b0, out_q.offset_overflow, out_q.value_size, out_q.key_len,
                          out_q.pad_len, out_q.right_offset, out_q.left_offset,
                          out_q.hash_byte, out_q.record_length, out_q.rec_offset};

  always_comb begin
    unique case (paddr[4:3])
      RegWidePtr:  prdata = {63'b0, wide_q};
      RegAlign:    prdata = {59'b0, shift_q};
      RegStartPos: prdata = {16'b0, start_q};
      default:     prdata = 64'b0;
    endcase
  end

  // byte lane insert and field completion
  always_comb begin
    acc_ins = acc_q;
    acc_ins[{idx_q[2:0], 3'b000} +: 8] = acc_q[{idx_q[2:0], 3'b000} +: 8] | b;
    idx_inc = idx_q + 4'd1;
    if (state_q == PH_PAD) begin
      fld_width = 4'd2;
    end else if (state_q == PH_FREE) begin
      fld_width = 4'd4;
    end else begin
      fld_width = wide_q ? 4'd8 : 4'd4;
    end
    fld_done   = idx_inc >= fld_width;
    shift_wide = {64'b0, acc_ins} << shift_q;
    ptr_ovf    = |shift_wide[127:OffsetBits];
  end

  // varint digit
  always_comb begin
    digit = b[7] ? ~b[6:0] : b[6:0];
    unique case (vcnt_q)
      3'd0:    vadd = {29'b0, digit};
      3'd1:    vadd = {22'b0, digit, 7'b0};
      3'd2:    vadd = {15'b0, digit, 14'b0};
      3'd3:    vadd = {8'b0, digit, 21'b0};
      3'd4:    vadd = {1'b0, digit, 28'b0};
      default: vadd = 36'b0;
    endcase
    vacc     = acc_q[35:0] + vadd;
    vsat     = (|vacc[35:32]) ? 32'hffff_ffff : vacc[31:0];
    vcnt_inc = (vcnt_q < 3'd5) ? vcnt_q + 3'd1 : vcnt_q;
    hcnt_inc = (hcnt_q == 8'hff) ? hcnt_q : hcnt_q + 8'd1;
    body     = LenBits'(pad_q) + LenBits'(key_q) + LenBits'(vsat);
    data_len = (LenBits + 1)'(hcnt_q + ((hcnt_q == 8'hff) ? 8'd0 : 8'd1))
               + (LenBits + 1)'(body);
    data_len_sat = data_len[LenBits] ? {LenBits{1'b1}} : data_len[LenBits-1:0];
    free_len = LenBits'(acc_ins[31:0]) + LenBits'(5);
    skip_dec = skip_q - LenBits'(1);
  end

  always_comb begin
    wide_d      = wide_q;
    shift_d     = shift_q;
    start_d     = start_q;
    state_d     = state_q;
    pos_d       = pos_q;
    rec_start_d = rec_start_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    vcnt_d      = vcnt_q;
    hcnt_d      = hcnt_q;
    skip_d      = skip_q;
    hash_d      = hash_q;
    left_d      = left_q;
    right_d     = right_q;
    pad_d       = pad_q;
    key_d       = key_q;
    ovf_d       = ovf_q;
    res_valid   = 1'b0;
    res         = '0;

    if (cfg_wr) begin
      unique case (paddr[4:3])
        RegWidePtr: wide_d = pwdata[0];
        RegAlign:   shift_d = pwdata[4:0];
        RegStartPos: begin
          start_d = pwdata[OffsetBits-1:0];
          pos_d   = pwdata[OffsetBits-1:0];
          state_d = PH_HUNT;
          hcnt_d  = 8'd0;
          skip_d  = '0;
          idx_d   = 4'd0;
          acc_d   = 64'b0;
          vcnt_d  = 3'd0;
        end
        default: ;
      endcase
    end else if (s_fire) begin
      pos_d = pos_q + OffsetBits'(1);
      unique case (state_q)
        PH_HUNT: begin
          if (b == MagicData || b == MagicFree) begin
            rec_start_d = pos_q;
            hcnt_d      = 8'd1;
            ovf_d       = 1'b0;
            idx_d       = 4'd0;
            acc_d       = 64'b0;
            vcnt_d      = 3'd0;
            state_d     = (b == MagicData) ? PH_HASH : PH_FREE;
          end
        end
        PH_HASH: begin
          hash_d  = b;
          hcnt_d  = hcnt_inc;
          idx_d   = 4'd0;
          acc_d   = 64'b0;
          vcnt_d  = 3'd0;
          state_d = PH_LEFT;
        end
        PH_LEFT, PH_RIGHT, PH_PAD, PH_FREE: begin
          hcnt_d = hcnt_inc;
          if (!fld_done) begin
            acc_d = acc_ins;
            idx_d = idx_inc;
          end else begin
            idx_d  = 4'd0;
            acc_d  = 64'b0;
            vcnt_d = 3'd0;
            priority case (1'b1)
              state_q == PH_LEFT: begin
                left_d  = shift_wide[OffsetBits-1:0];
                ovf_d   = ovf_q | ptr_ovf;
                state_d = PH_RIGHT;
              end
              state_q == PH_RIGHT: begin
                right_d = shift_wide[OffsetBits-1:0];
                ovf_d   = ovf_q | ptr_ovf;
                state_d = PH_PAD;
              end
              state_q == PH_PAD: begin
                pad_d   = acc_ins[15:0];
                state_d = PH_KEY;
              end
              default: begin
                res_valid         = 1'b1;
                res.record_kind   = 1'b1;
                res.rec_offset    = rec_start_q;
                res.record_length = free_len;
                skip_d  = LenBits'(acc_ins[31:0]);
                state_d = (acc_ins[31:0] != 32'b0) ? PH_SKIP : PH_HUNT;
              end
            endcase
          end
        end
        PH_KEY: begin
          hcnt_d = hcnt_inc;
          if (b[7]) begin
            acc_d  = {28'b0, vacc};
            vcnt_d = vcnt_inc;
          end else begin
            key_d   = vsat;
            idx_d   = 4'd0;
            acc_d   = 64'b0;
            vcnt_d  = 3'd0;
            state_d = PH_VAL;
          end
        end
        PH_VAL: begin
          hcnt_d = hcnt_inc;
          if (b[7]) begin
            acc_d  = {28'b0, vacc};
            vcnt_d = vcnt_inc;
          end else begin
            res_valid           = 1'b1;
            res.record_kind     = 1'b0;
            res.rec_offset      = rec_start_q;
            res.record_length   = data_len_sat;
            res.hash_byte       = hash_q;
            res.left_offset     = left_q;
            res.right_offset    = right_q;
            res.pad_len         = pad_q;
            res.key_len         = key_q;
            res.value_size      = vsat;
            res.offset_overflow = ovf_q;
            skip_d  = body;
            idx_d   = 4'd0;
            acc_d   = 64'b0;
            vcnt_d  = 3'd0;
            state_d = (body != '0) ? PH_SKIP : PH_HUNT;
          end
        end
        PH_SKIP: begin
          if (skip_q != '0) begin
            skip_d = skip_dec;
          end
          if (skip_q == '0 || skip_dec == '0) begin
            state_d = PH_HUNT;
          end
        end
        default: begin
          state_d = PH_HUNT;
          idx_d   = 4'd0;
          acc_d   = 64'b0;
          vcnt_d  = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q      <= 1'b0;
      shift_q     <= AlignReset;
      start_q     <= '0;
      state_q     <= PH_HUNT;
      pos_q       <= '0;
      rec_start_q <= '0;
      idx_q       <= 4'd0;
      acc_q       <= 64'b0;
      vcnt_q      <= 3'd0;
      hcnt_q      <= 8'd0;
      skip_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      wide_q      <= wide_d;
      shift_q     <= shift_d;
      start_q     <= start_d;
      state_q     <= state_d;
      pos_q       <= pos_d;
      rec_start_q <= rec_start_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      vcnt_q      <= vcnt_d;
      hcnt_q      <= hcnt_d;
      skip_q      <= skip_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q  <= hash_d;
    left_q  <= left_d;
    right_q <= right_d;
    pad_q   <= pad_d;
    key_q   <= key_d;
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (s_fire && res_valid) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (s_fire && res_valid) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  `HDBHP_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  `HDBHP_ASSERT_NOW(a_no_push_on_full, s_fire && res_valid && !cfg_wr, !skid_valid_q)
  `HDBHP_ASSERT_NEXT(a_result_lands, s_fire && res_valid && !cfg_wr, out_valid_q)
  `HDBHP_ASSERT_NOW(a_skip_nonzero, state_q == PH_SKIP, skip_q != '0)
  `HDBHP_ASSERT_NOW(a_header_counted, state_q == PH_KEY || state_q == PH_VAL, hcnt_q != 8'd0)

endmodule

FILE: tb/hash_db_record_header_parser_checker.sv
module hash_db_record_header_parser_checker import hdbhp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // data_byte
  input  logic [7:0]   s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rec_offset, record_length, hash_byte, left_offset, right_offset,
  // pad_len, key_len, value_size, offset_overflow, zero fill
  input  logic [271:0] m_axis_tdata,
  // record_kind
  input  logic         m_axis_tuser,
  output logic [15:0]  pending_o,
  output int unsigned  errors_o
);

  localparam logic KindData = 1'b0;
  localparam logic KindFree = 1'b1;

  logic        wide_cfg;
  logic [4:0]  shift_cfg;
  logic [47:0] start_cfg;

  phase_e      ph;
  logic [47:0] pos;
  logic [47:0] rec_start;
  logic [3:0]  byte_idx;
  logic [63:0] acc;
  int unsigned digits;
  int unsigned hdr_cnt;
  logic [33:0] skip_left;
  logic [7:0]  cap_hash;
  logic [63:0] cap_left;
  logic [63:0] cap_right;
  logic [15:0] cap_pad;
  logic [31:0] cap_key;
  logic [31:0] cap_val;
  bit          ovf;

  result_t     header_q[$];
  int unsigned err_cnt;

  function automatic void clear_field();
    byte_idx = '0;
    acc      = '0;
    digits   = 0;
  endfunction

  function automatic void bump_header();
    if (hdr_cnt < 255) hdr_cnt++;
  endfunction

  function automatic logic [33:0] sat34(input logic [63:0] v);
    return (v > 64'h3_ffff_ffff) ? 34'h3_ffff_ffff : v[33:0];
  endfunction

  function automatic logic [31:0] sat32();
    return (acc > 64'hffff_ffff) ? 32'hffff_ffff : acc[31:0];
  endfunction

  function automatic logic [63:0] shift_ptr(input logic [63:0] v);
    logic [63:0] sh;
    if (shift_cfg != 0 && (v >> (64 - int'(shift_cfg))) != 0) ovf = 1'b1;
    sh = v << shift_cfg;
    if (sh[63:48] != 0) ovf = 1'b1;
    return sh;
  endfunction

  // true on the final digit
  function automatic bit varint_add(input logic [7:0] b);
    logic [63:0] digit;
    digit = b[7] ? 64'(8'd255 - b) : 64'(b);
    if (digits < 5) begin
      acc = acc + (digit << (7 * digits));
      digits++;
    end
    return !b[7];
  endfunction

  function automatic void end_record(input logic [63:0] skip);
    skip_left = skip[33:0];
    ph = (skip_left != 0) ? PH_SKIP : PH_HUNT;
    clear_field();
  endfunction

  function automatic void reset_parser();
    wide_cfg  = 1'b0;
    shift_cfg = AlignReset;
    start_cfg = '0;
    ph        = PH_HUNT;
    pos       = '0;
    rec_start = '0;
    hdr_cnt   = 0;
    skip_left = '0;
    ovf       = 1'b0;
    cap_hash  = '0;
    cap_left  = '0;
    cap_right = '0;
    cap_pad   = '0;
    cap_key   = '0;
    cap_val   = '0;
    clear_field();
  endfunction

  function automatic void write_reg(input logic [1:0] idx, input logic [63:0] v);
    case (idx)
      RegWidePtr: wide_cfg = v[0];
      RegAlign: shift_cfg = v[4:0];
      RegStartPos: begin
        start_cfg = v[47:0];
        pos       = start_cfg;
        ph        = PH_HUNT;
        hdr_cnt   = 0;
        skip_left = '0;
        clear_field();
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b, output bit emit, output result_t r);
    logic [47:0] here;
    int unsigned width;
    logic [63:0] body;
    logic [63:0] len;
    emit  = 1'b0;
    r     = '0;
    here  = pos;
    width = wide_cfg ? 8 : 4;
    pos   = pos + 48'd1;
    case (ph)
      PH_HUNT: begin
        if (b == MagicData || b == MagicFree) begin
          rec_start = here;
          hdr_cnt   = 1;
          ovf       = 1'b0;
          cap_hash  = '0;
          cap_left  = '0;
          cap_right = '0;
          cap_pad   = '0;
          cap_key   = '0;
          cap_val   = '0;
          clear_field();
          ph = (b == MagicData) ? PH_HASH : PH_FREE;
        end
      end
      PH_HASH: begin
        cap_hash = b;
        bump_header();
        clear_field();
        ph = PH_LEFT;
      end
      PH_LEFT, PH_RIGHT, PH_PAD, PH_FREE: begin
        acc = acc | (64'(b) << (8 * byte_idx[2:0]));
        byte_idx = byte_idx + 4'd1;
        bump_header();
        if (ph == PH_PAD) width = 2;
        else if (ph == PH_FREE) width = 4;
        if (byte_idx >= width) begin
          if (ph == PH_LEFT) begin
            cap_left = shift_ptr(acc);
            ph = PH_RIGHT;
            clear_field();
          end else if (ph == PH_RIGHT) begin
            cap_right = shift_ptr(acc);
            ph = PH_PAD;
            clear_field();
          end else if (ph == PH_PAD) begin
            cap_pad = acc[15:0];
            ph = PH_KEY;
            clear_field();
          end else begin
            len = 64'd5 + {32'd0, acc[31:0]};
            emit = 1'b1;
            r.record_kind   = KindFree;
            r.rec_offset    = rec_start;
            r.record_length = sat34(len);
            end_record({32'd0, acc[31:0]});
          end
        end
      end
      PH_KEY: begin
        bump_header();
        if (varint_add(b)) begin
          cap_key = sat32();
          ph = PH_VAL;
          clear_field();
        end
      end
      PH_VAL: begin
        bump_header();
        if (varint_add(b)) begin
          cap_val = sat32();
          body = {48'd0, cap_pad} + {32'd0, cap_key} + {32'd0, cap_val};
          len  = 64'(hdr_cnt) + body;
          emit = 1'b1;
          r.record_kind     = KindData;
          r.rec_offset      = rec_start;
          r.record_length   = sat34(len);
          r.hash_byte       = cap_hash;
          r.left_offset     = cap_left[47:0];
          r.right_offset    = cap_right[47:0];
          r.pad_len         = cap_pad;
          r.key_len         = cap_key;
          r.value_size      = cap_val;
          r.offset_overflow = ovf;
          end_record(body);
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 34'd1;
        if (skip_left == 0) ph = PH_HUNT;
      end
      default: begin
        ph = PH_HUNT;
        clear_field();
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit      emit;
    result_t fresh;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      reset_parser();
      header_q.delete();
      err_cnt = 0;
      pending_o <= '0;
      errors_o  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[4:3], pwdata);
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, emit, fresh);
        if (emit) header_q.push_back(fresh);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'({m_axis_tuser, m_axis_tdata[266:0]});
        if (header_q.size() == 0) begin
          $error("unexpected result transfer: rec_offset %h", got.rec_offset);
          err_cnt++;
        end else begin
          want = header_q.pop_front();
          check_field("record_kind", 64'(want.record_kind), 64'(got.record_kind));
          check_field("rec_offset", 64'(want.rec_offset), 64'(got.rec_offset));
          check_field("record_length", 64'(want.record_length), 64'(got.record_length));
          check_field("hash_byte", 64'(want.hash_byte), 64'(got.hash_byte));
          check_field("left_offset", 64'(want.left_offset), 64'(got.left_offset));
          check_field("right_offset", 64'(want.right_offset), 64'(got.right_offset));
          check_field("pad_len", 64'(want.pad_len), 64'(got.pad_len));
          check_field("key_len", 64'(want.key_len), 64'(got.key_len));
          check_field("value_size", 64'(want.value_size), 64'(got.value_size));
          check_field("offset_overflow", 64'(want.offset_overflow),
                      64'(got.offset_overflow));
          check_field("zero fill", 64'd0, 64'(m_axis_tdata[271:267]));
        end
      end
      pending_o <= 16'(header_q.size());
      errors_o  <= err_cnt;
    end
  end

endmodule

FILE: tb/hash_db_record_header_parser_core_tb.sv
module hash_db_record_header_parser_core_tb;
  import hdbhp_pkg::*;

  localparam int unsigned ItemTarget = 1900;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [271:0] m_axis_tdata;
  logic         m_axis_tuser;

  logic [15:0]  pending;
  int unsigned  mismatches;

  bit           calm = 1'b0;
  bit           src_gaps = 1'b1;
  bit           sink_gaps = 1'b1;
  int unsigned  stall_left = 0;
  int unsigned  fed_bytes = 0;
  bit           wide_ptr = 1'b0;

  hash_db_record_header_parser_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hash_db_record_header_parser_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending_o     (pending),
    .errors_o      (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result sink with random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (calm || !sink_gaps) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (src_gaps && !calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    fed_bytes++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) send_byte(v[8*i +: 8]);
  endtask

  task automatic send_varint(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    while (r >= 128) begin
      send_byte(8'd255 - {1'b0, r[6:0]});
      r = r >> 7;
    end
    send_byte(r[7:0]);
  endtask

  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 9))
      0: return MagicData;
      1: return MagicFree;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_body(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(body_byte());
  endtask

  task automatic send_data_rec(input logic [7:0] hash, input logic [63:0] left,
                               input logic [63:0] right, input logic [15:0] pad,
                               input logic [31:0] key, input logic [31:0] val);
    send_byte(MagicData);
    send_byte(hash);
    send_le(left, wide_ptr ? 8 : 4);
    send_le(right, wide_ptr ? 8 : 4);
    send_le(64'(pad), 2);
    send_varint(key);
    send_varint(val);
  endtask

  task automatic send_free_rec(input logic [31:0] size);
    send_byte(MagicFree);
    send_le(64'(size), 4);
  endtask

  // sender holds off until every header has come out and the block has settled
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    s_axis_tvalid <= 1'b0;
    while (quiet < 4) begin
      @(posedge clk_i);
      if (pending == 0 && !m_axis_tvalid) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegWidePtr) wide_ptr = val[0];
  endtask

  function automatic logic [4:0] pick_shift();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic logic [63:0] pick_pos();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return 64'hffff_ffff_ffff;
      2: return 64'hffff_ffff_ffff - 64'($urandom_range(0, 40));
      default: return {16'd0, 16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [63:0] pick_ptr();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {32'($urandom), 32'($urandom)};
      default: return 64'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    return ($urandom_range(0, 9) == 0) ? 32'($urandom_range(128, 200))
                                       : 32'($urandom_range(0, 8));
  endfunction

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    bit          jumped;
    int          n;
    int          sel;
    logic [15:0] pad;
    logic [31:0] key;
    logic [31:0] val;
    logic [7:0]  b;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: noise, minimal data block, free blocks, skipped magic bytes
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h7f);
    send_data_rec(8'h00, 64'hffff_ffff, 64'd0, 16'd0, 32'd0, 32'd0);
    send_free_rec(32'd0);
    send_free_rec(32'd2);
    send_byte(MagicData);
    send_byte(MagicFree);
    send_data_rec(8'hff, 64'd1, 64'd2, 16'd1, 32'd128, 32'd5000);
    wait_idle();
    reg_write(RegStartPos, 64'd0);

    // maximal free size, then position wrap
    send_free_rec(32'hffff_ffff);
    wait_idle();
    reg_write(RegStartPos, 64'hffff_ffff_fffe);
    send_byte(8'h11);
    send_data_rec(8'h5a, 64'd3, 64'd4, 16'd0, 32'd0, 32'd0);

    // varint running past five digits and a header count that saturates
    send_byte(MagicData);
    send_byte(8'h01);
    send_le(64'd0, 8);
    send_le(64'd0, 2);
    for (int i = 0; i < 300; i++) send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h00);
    wait_idle();
    reg_write(RegStartPos, 64'd0);

    // wide pointers with overflow and maximal sizes
    reg_write(RegWidePtr, 64'd1);
    reg_write(RegAlign, 64'd16);
    send_data_rec(8'h80, '1, 64'h0000_ffff_ffff_ffff, 16'hffff, 32'hffff_ffff,
                  32'hffff_ffff);
    wait_idle();
    reg_write(RegStartPos, 64'h1234_5678_9abc);
    reg_write(RegAlign, 64'd31);
    send_data_rec(8'h01, 64'h1_0000_0001, 64'd0, 16'd0, 32'd0, 32'd0);
    wait_idle();
    reg_write(RegAlign, 64'd0);
    send_data_rec(8'h02, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff, 16'd0, 32'd1, 32'd0);
    send_byte(8'h33);

    // pointer width changed in the middle of a field
    wait_idle();
    reg_write(RegWidePtr, 64'd0);
    send_byte(MagicData);
    send_byte(8'h44);
    send_le(64'h0000_beef, 2);
    wait_idle();
    reg_write(RegWidePtr, 64'd1);
    send_le(64'h1122_3344_5566, 6);
    send_le(64'd7, 8);
    send_le(64'd0, 2);
    send_varint(32'd0);
    send_varint(32'd0);
    send_byte(MagicData);
    send_byte(8'h55);
    send_le(64'h0102_0304_0506, 6);
    wait_idle();
    reg_write(RegWidePtr, 64'd0);
    reg_write(RegAlign, 64'd4);
    send_byte(8'h07);
    send_le(64'h0a0b_0c0d, 4);
    send_le(64'd0, 2);
    send_varint(32'd0);
    send_varint(32'd0);

    // random phases
    jumped = 1'b0;
    while (fed_bytes < ItemTarget - 100) begin
      wait_idle();
      if ($urandom_range(0, 1)) reg_write(RegWidePtr, 64'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) reg_write(RegAlign, 64'(pick_shift()));
      if (jumped || $urandom_range(0, 2) == 0) reg_write(RegStartPos, pick_pos());
      jumped    = 1'b0;
      src_gaps  = ($urandom_range(0, 2) != 0);
      sink_gaps = ($urandom_range(0, 2) != 0);
      calm      = (fed_bytes > ItemTarget - 400);
      n = $urandom_range(3, 10);
      for (int k = 0; k < n && !jumped; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          pad = 16'($urandom_range(0, 3));
          key = pick_size();
          val = pick_size();
          send_data_rec(8'($urandom), pick_ptr(), pick_ptr(), pad, key, val);
          send_body(int'(pad) + int'(key) + int'(val));
        end else if (sel < 70) begin
          key = 32'($urandom_range(0, 8));
          send_free_rec(key);
          send_body(key);
        end else if (sel < 82) begin
          repeat ($urandom_range(1, 5)) begin
            b = 8'($urandom);
            if (b == MagicData || b == MagicFree) b = b ^ 8'h01;
            send_byte(b);
          end
        end else if (sel < 94) begin
          send_byte($urandom_range(0, 1) ? MagicData : MagicFree);
          repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
          jumped = 1'b1;
        end else begin
          if ($urandom_range(0, 1))
            send_data_rec(8'($urandom), pick_ptr(), pick_ptr(), 16'($urandom),
                          32'($urandom), 32'($urandom));
          else
            send_free_rec(32'($urandom));
          jumped = 1'b1;
        end
      end
    end

    calm = 1'b1;
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
